FILE: rtl/gbi_pkg.sv
// Shared types, constants and table builders for the Gaussian beam intensity block.
package gbi_pkg;

    localparam logic [63:0] ONE63       = 64'h8000_0000_0000_0000;
    localparam logic [47:0] HALF_PI_Q47 = 48'hC90F_DAA2_2169;
    localparam logic [18:0] T_CLAMP     = 19'd327680;
    localparam logic [39:0] RATIO_LIMIT = 40'h10_0000_0000;
    localparam int          XTAB_N      = 33;
    localparam int          DEN_W       = 112;

    typedef enum logic [2:0] {
        REG_POWER,
        REG_RADIUS,
        REG_CENTRE_X,
        REG_CENTRE_Y,
        REG_CENTRE_Z,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z
    } reg_idx_t;

    typedef struct packed {
        logic        clipped;
        logic [31:0] intensity;
    } out_beat_t;

    typedef logic [63:0] xtab_t [XTAB_N];

    // exp(-k / 2^b) in Q.63, alternating Taylor series
    function automatic logic [63:0] exp_entry(input logic [63:0] k, input int b);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = ONE63;
        pos  = ONE63;
        neg  = '0;
        for (int n = 1; n <= 24; n++)
        begin
            term = ((term >> b) * k) / 64'(n);
            if ((n % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return pos - neg;
    endfunction

    // exp(-1)^i for i = 0..32, built by truncated products
    function automatic xtab_t build_xtab(input int b);
        xtab_t        t;
        logic [63:0]  eone;
        logic [63:0]  x;
        logic [127:0] p;
        eone = exp_entry(64'(1) << b, b);
        x    = ONE63;
        for (int i = 0; i < XTAB_N; i++)
        begin
            t[i] = x;
            p    = 128'(x) * 128'(eone);
            x    = p[126:63];
        end
        return t;
    endfunction

endpackage

FILE: rtl/gbi_skid.sv
// Two-entry output buffer between the pipeline and the result stream.
module gbi_skid
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gbi_pkg::out_beat_t  din,
    output logic                full,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // beam_intensity
    output logic [0:0]          m_axis_tuser    // clipped
);
    import gbi_pkg::*;

    logic [1:0] count_reg;
    out_beat_t  head_reg;
    out_beat_t  tail_reg;
    logic       pop;

    assign pop           = (count_reg != 2'd0) && m_axis_tready;
    assign full          = (count_reg == 2'd2);
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = head_reg.intensity;
    assign m_axis_tuser  = head_reg.clipped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
                head_reg <= tail_reg;
            else if (push)
                head_reg <= din;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                head_reg <= din;
            else
                tail_reg <= din;
        end
    end

endmodule

FILE: rtl/gaussian_beam_intensity.sv
// Top level: pipelined Gaussian beam surface intensity, one point per beat.
//
//  channel   dir  beat contents
//  s_axis    in   tdata: point_x, point_y, point_z (32b each, low first)
//  m_axis    out  tdata: beam_intensity; tuser: clipped
//  cfg       in   cfg_we / cfg_index / cfg_data register writes
//
// One point accepted per cycle while the output buffer is not full; the pipeline
// holds the two bit-per-stage dividers (20 and 32 stages).
// After a radius write the denominator settles through rsq_reg, dp*_reg and den_reg.
// Reset clears valid bits, the output buffer and the registers to defaults.
// A stalled output fills the two-entry buffer, then holds the whole pipeline.
module gaussian_beam_intensity #(
    parameter int EXP_TABLE_BITS  = 8,
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // point_x, point_y, point_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // beam_intensity
    output logic [0:0]   m_axis_tuser    // clipped
);
    import gbi_pkg::*;

    localparam int FR     = 32 - EXP_TABLE_BITS;
    localparam int NSH    = 2 * COORD_FRAC_BITS - 16;
    localparam int NUM_W  = 96 + NSH;
    localparam int CMP_W  = DEN_W + 1;
    localparam int TAB_N  = (1 << EXP_TABLE_BITS) + 1;
    localparam int TAB_AW = EXP_TABLE_BITS + 1;
    localparam int NST    = 68;

    typedef logic [63:0] etab_t [TAB_N];

    function automatic etab_t build_etab();
        etab_t t;
        for (int i = 0; i < TAB_N; i++)
            t[i] = exp_entry(64'(i), EXP_TABLE_BITS);
        return t;
    endfunction

    localparam etab_t ETAB = build_etab();
    localparam xtab_t XTAB = build_xtab(EXP_TABLE_BITS);

    // configuration
    logic [31:0] power_reg, radius_reg, cx_reg, cy_reg, cz_reg;
    logic [15:0] ax_reg, ay_reg, az_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg  <= 32'd0;
            radius_reg <= 32'd65536;
            cx_reg     <= 32'd0;
            cy_reg     <= 32'd0;
            cz_reg     <= 32'd0;
            ax_reg     <= 16'd0;
            ay_reg     <= 16'd0;
            az_reg     <= 16'd16384;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_POWER:    power_reg  <= cfg_data;
                REG_RADIUS:   radius_reg <= cfg_data;
                REG_CENTRE_X: cx_reg     <= cfg_data;
                REG_CENTRE_Y: cy_reg     <= cfg_data;
                REG_CENTRE_Z: cz_reg     <= cfg_data;
                REG_AXIS_X:   ax_reg     <= cfg_data[15:0];
                REG_AXIS_Y:   ay_reg     <= cfg_data[15:0];
                REG_AXIS_Z:   az_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0]        rad_eff;
    logic signed [15:0] nx, ny, nz;

    assign rad_eff = (radius_reg == 32'd0) ? 32'd1 : radius_reg;
    assign nx      = ax_reg;
    assign ny      = ay_reg;
    assign nz      = az_reg;

    // denominator R^2 * pi/2, free running from the registers
    logic [63:0]      rsq_reg;
    logic [63:0]      dp0_reg, dp2_reg;
    logic [47:0]      dp1_reg, dp3_reg;
    logic [DEN_W-1:0] den_reg;

    always_ff @(posedge clk)
    begin
        rsq_reg <= 64'(rad_eff) * 64'(rad_eff);
        dp0_reg <= rsq_reg[31:0]  * HALF_PI_Q47[31:0];
        dp1_reg <= rsq_reg[31:0]  * HALF_PI_Q47[47:32];
        dp2_reg <= rsq_reg[63:32] * HALF_PI_Q47[31:0];
        dp3_reg <= rsq_reg[63:32] * HALF_PI_Q47[47:32];
        den_reg <= DEN_W'(dp0_reg) + (DEN_W'(dp1_reg) << 32)
                 + (DEN_W'(dp2_reg) << 32) + (DEN_W'(dp3_reg) << 64);
    end

    // pipeline control
    logic           en;
    logic           full;
    logic           push;
    logic [NST-1:0] vld_reg;

    assign en            = !full;
    assign s_axis_tready = en;
    assign push          = en && vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    // offset from centre
    logic signed [32:0] dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
                    - $signed({cx_reg[31], cx_reg});
            dy_reg <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
                    - $signed({cy_reg[31], cy_reg});
            dz_reg <= $signed({s_axis_tdata[95], s_axis_tdata[95:64]})
                    - $signed({cz_reg[31], cz_reg});
        end
    end

    // cross product terms
    logic signed [48:0] pb_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb_reg[0] <= dy_reg * nz;
            pb_reg[1] <= dz_reg * ny;
            pb_reg[2] <= dz_reg * nx;
            pb_reg[3] <= dx_reg * nz;
            pb_reg[4] <= dx_reg * ny;
            pb_reg[5] <= dy_reg * nx;
        end
    end

    // |c_i| * 4
    logic signed [49:0] ed  [3];
    logic [49:0]        mag [3];
    logic [51:0]        c4_reg [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            ed[l]  = pb_reg[2*l] - pb_reg[2*l+1];
            mag[l] = ed[l][49] ? 50'(-ed[l]) : 50'(ed[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            for (int l = 0; l < 3; l++)
                c4_reg[l] <= {mag[l], 2'b00};
    end

    // c4 / R, one quotient bit per stage
    logic [51:0] r1_reg   [3][21];
    logic [19:0] q1_reg   [3][21];
    logic        ovf1_reg [3][21];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r1_reg[l][0]   <= c4_reg[l];
                q1_reg[l][0]   <= '0;
                ovf1_reg[l][0] <= c4_reg[l] >= {rad_eff, 20'd0};
            end
        end

        for (genvar g = 0; g < 20; g++)
        begin : g_div1
            logic [51:0] dv;
            logic        ge;

            assign dv = 52'(rad_eff) << (19 - g);
            assign ge = r1_reg[l][g] >= dv;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r1_reg[l][g+1]   <= ge ? r1_reg[l][g] - dv : r1_reg[l][g];
                    q1_reg[l][g+1]   <= {q1_reg[l][g][18:0], ge};
                    ovf1_reg[l][g+1] <= ovf1_reg[l][g];
                end
            end
        end
    end

    // clamp, square, sum
    logic [18:0] t_reg  [3];
    logic [37:0] sq_reg [3];
    logic [39:0] rsum;
    logic [39:0] r_reg;
    logic        zg_reg;

    assign rsum = 40'(sq_reg[0]) + 40'(sq_reg[1]) + 40'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                t_reg[l]  <= (ovf1_reg[l][20] || (q1_reg[l][20] > 20'(T_CLAMP)))
                           ? T_CLAMP : q1_reg[l][20][18:0];
                sq_reg[l] <= t_reg[l] * t_reg[l];
            end
            r_reg  <= rsum;
            zg_reg <= rsum > RATIO_LIMIT;
        end
    end

    // table lookups
    logic [40:0]       a41;
    logic [8:0]        ip;
    logic [5:0]        xidx;
    logic [TAB_AW-1:0] k0, k1;
    logic [63:0]       e0_h_reg, e1_h_reg, xv_h_reg;
    logic [FR-1:0]     rm_h_reg;
    logic              zh_reg;

    assign a41  = {r_reg, 1'b0};
    assign ip   = a41[40:32];
    assign xidx = (zg_reg || (ip > 9'd32)) ? 6'd0 : ip[5:0];
    assign k0   = TAB_AW'(a41[31:FR]);
    assign k1   = k0 + 1'b1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_h_reg <= ETAB[k0];
            e1_h_reg <= ETAB[k1];
            xv_h_reg <= XTAB[xidx];
            rm_h_reg <= a41[FR-1:0];
            zh_reg   <= zg_reg;
        end
    end

    // interpolation
    logic [63:0]    df_reg, e0_i_reg, xv_i_reg;
    logic [FR-1:0]  rm_i_reg;
    logic           zi_reg;
    logic [31+FR:0] ph_reg, pl_reg;
    logic [63:0]    e0_j_reg, xv_j_reg;
    logic           zj_reg;
    logic [95:0]    prod;
    logic [95:0]    prod_sh;
    logic [63:0]    m_reg, xv_k_reg;
    logic           zk_reg;

    assign prod    = (96'(ph_reg) << 32) + 96'(pl_reg);
    assign prod_sh = prod >> FR;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            df_reg   <= (e0_h_reg > e1_h_reg) ? e0_h_reg - e1_h_reg : 64'd0;
            e0_i_reg <= e0_h_reg;
            xv_i_reg <= xv_h_reg;
            rm_i_reg <= rm_h_reg;
            zi_reg   <= zh_reg;

            ph_reg   <= df_reg[63:32] * rm_i_reg;
            pl_reg   <= df_reg[31:0]  * rm_i_reg;
            e0_j_reg <= e0_i_reg;
            xv_j_reg <= xv_i_reg;
            zj_reg   <= zi_reg;

            m_reg    <= e0_j_reg - prod_sh[63:0];
            xv_k_reg <= xv_j_reg;
            zk_reg   <= zj_reg;
        end
    end

    // g = X * m, then P * g
    logic [63:0]      mp_reg [4];
    logic             zl_reg;
    logic [127:0]     gsum;
    logic [63:0]      g_reg;
    logic             zm_reg;
    logic [63:0]      nh_reg, nl_reg;
    logic             zn_reg;
    logic [NUM_W-1:0] num_reg;
    logic             zo_reg;

    assign gsum = 128'(mp_reg[0]) + (128'(mp_reg[1]) << 32)
                + (128'(mp_reg[2]) << 32) + (128'(mp_reg[3]) << 64);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_reg[0] <= xv_k_reg[31:0]  * m_reg[31:0];
            mp_reg[1] <= xv_k_reg[31:0]  * m_reg[63:32];
            mp_reg[2] <= xv_k_reg[63:32] * m_reg[31:0];
            mp_reg[3] <= xv_k_reg[63:32] * m_reg[63:32];
            zl_reg    <= zk_reg;

            g_reg  <= gsum[126:63];
            zm_reg <= zl_reg;

            nh_reg <= power_reg * g_reg[63:32];
            nl_reg <= power_reg * g_reg[31:0];
            zn_reg <= zm_reg;

            num_reg <= (NUM_W'(nh_reg) << (32 + NSH)) + (NUM_W'(nl_reg) << NSH);
            zo_reg  <= zn_reg;
        end
    end

    // num / den, one quotient bit per stage
    logic [NUM_W-33:0] acc0;
    logic [DEN_W-1:0]  r2_reg   [33];
    logic [31:0]       lo2_reg  [33];
    logic [31:0]       q2_reg   [33];
    logic              sat2_reg [33];
    logic              z2_reg   [33];

    assign acc0 = num_reg[NUM_W-1:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg[0]   <= DEN_W'(acc0);
            lo2_reg[0]  <= num_reg[31:0];
            q2_reg[0]   <= '0;
            sat2_reg[0] <= CMP_W'(acc0) >= CMP_W'(den_reg);
            z2_reg[0]   <= zo_reg;
        end
    end

    for (genvar g = 0; g < 32; g++)
    begin : g_div2
        logic [CMP_W-1:0] acc;
        logic [CMP_W-1:0] sub;
        logic             ge;

        assign acc = {r2_reg[g], lo2_reg[g][31]};
        assign sub = acc - {1'b0, den_reg};
        assign ge  = acc >= {1'b0, den_reg};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r2_reg[g+1]   <= ge ? sub[DEN_W-1:0] : acc[DEN_W-1:0];
                lo2_reg[g+1]  <= {lo2_reg[g][30:0], 1'b0};
                q2_reg[g+1]   <= {q2_reg[g][30:0], ge};
                sat2_reg[g+1] <= sat2_reg[g];
                z2_reg[g+1]   <= z2_reg[g];
            end
        end
    end

    out_beat_t res;

    always_comb
    begin
        res.clipped = !z2_reg[32] && sat2_reg[32];
        if (z2_reg[32])
            res.intensity = 32'd0;
        else if (sat2_reg[32])
            res.intensity = 32'hFFFF_FFFF;
        else
            res.intensity = q2_reg[32];
    end

    gbi_skid u_skid
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .din           (res),
        .full          (full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'hFFFF_FFFF))
        else $error("clipped beat without saturated intensity");

    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with no result waiting");

    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(push))
        else $error("result beat appeared without a pipeline push");

endmodule
